[design/lhp_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the latency histogram percentile block
// used by the controller, the datapath, the top level and the checker

package lhp_pkg;

    // field widths
    localparam int LAT_W      = 32;
    localparam int PCT_W      = 14;
    localparam int RES_W      = 10;
    localparam int CNT_W      = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    // largest limit that the register can take effect with
    localparam int LIM_MAX    = 1022;

    // percentile arithmetic: rank met once 10000 * running count >= p * total
    localparam int PROD_W     = 46;
    localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;

    // commands from controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic add_write;
        logic q_mul;
        logic q_load;
        logic q_walk;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic in_query;
        logic q_early;
        logic walk_done;
        logic out_busy;
    } sts_t;

endpackage

[design/lhp_ctrl.sv]
`timescale 1ns / 1ps
// controller of the latency histogram: sequences clear, add and query steps
// depends on lhp_pkg for the command and status structs

module lhp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lhp_pkg::sts_t sts,
    output lhp_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b000_0001,
        S_IDLE  = 7'b000_0010,
        S_ADD   = 7'b000_0100,
        S_QMUL  = 7'b000_1000,
        S_QLOAD = 7'b001_0000,
        S_QWALK = 7'b010_0000,
        S_DONE  = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // input side handshake
    assign s_tready = (state_reg == S_IDLE) && !cfg_we;
    assign accept   = s_tready && s_tvalid;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (sts.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (!sts.in_query)    state_next = S_ADD;
                    else if (sts.q_early) state_next = S_DONE;
                    else                  state_next = S_QMUL;
                end
            end
            S_ADD:   state_next = S_IDLE;
            S_QMUL:  state_next = S_QLOAD;
            S_QLOAD: state_next = S_QWALK;
            S_QWALK: begin
                if (sts.walk_done) state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
        // a limit write restarts the clear pass
        if (cfg_we) state_next = S_CLEAR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands
    always_comb begin
        cmd            = '0;
        cmd.clear_step = (state_reg == S_CLEAR) && !cfg_we;
        cmd.accept     = accept;
        cmd.add_write  = (state_reg == S_ADD);
        cmd.q_mul      = (state_reg == S_QMUL);
        cmd.q_load     = (state_reg == S_QLOAD);
        cmd.q_walk     = (state_reg == S_QWALK);
        cmd.out_load   = (state_reg == S_DONE) && !sts.out_busy;
    end

endmodule

[design/lhp_dp.sv]
`timescale 1ns / 1ps
// datapath of the latency histogram: bin memory, total, limit, rank compare,
// bin walk and output register; depends on lhp_pkg

module lhp_dp #(
    parameter int BIN_COUNT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lhp_pkg::RES_W-1:0]       cfg_wdata,
    input  logic                            s_tuser,
    input  logic [lhp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lhp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  lhp_pkg::cmd_t                   cmd,
    output lhp_pkg::sts_t                   sts
);

    localparam int IDX_W = $clog2(BIN_COUNT);
    localparam int CAP   = (BIN_COUNT - 2 < lhp_pkg::LIM_MAX) ? BIN_COUNT - 2
                                                              : lhp_pkg::LIM_MAX;

    // bin memory
    logic [lhp_pkg::CNT_W-1:0] mem [BIN_COUNT];
    logic [lhp_pkg::CNT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]          rd_addr, wr_addr;
    logic [lhp_pkg::CNT_W-1:0] wr_data;
    logic                      wr_en;

    logic [lhp_pkg::RES_W-1:0] lim_reg;
    logic [lhp_pkg::CNT_W-1:0] total_reg;
    logic [IDX_W-1:0]          clr_addr_reg;
    logic [IDX_W-1:0]          add_addr_reg;
    logic [lhp_pkg::PCT_W-1:0] pct_reg;
    logic [lhp_pkg::PROD_W-1:0] prod_reg;
    logic [lhp_pkg::PROD_W-1:0] rem_reg;
    logic [IDX_W-1:0]          walk_addr_reg;
    logic [IDX_W-1:0]          data_idx_reg;
    logic                      data_valid_reg;
    logic [lhp_pkg::RES_W-1:0] ans_reg;
    logic                      out_valid_reg;
    logic [lhp_pkg::RES_W-1:0] out_data_reg;

    logic [IDX_W-1:0]          last_idx;
    logic [lhp_pkg::LAT_W-1:0] lat;
    logic [lhp_pkg::PCT_W-1:0] pct;
    logic [IDX_W-1:0]          add_idx;
    logic [lhp_pkg::PROD_W-1:0] bin_ext;
    logic [lhp_pkg::PROD_W-1:0] scaled;
    logic                      hit, at_last;
    logic                      walk_end;
    logic                      no_rank;

    // input fields
    assign lat = s_tdata[lhp_pkg::LAT_W-1:0];
    assign pct = s_tdata[lhp_pkg::LAT_W +: lhp_pkg::PCT_W];

    // overflow bin sits right after the limit
    assign last_idx = IDX_W'({1'b0, lim_reg} + 11'd1);

    // bin index of a sample: clamp negatives, route large ones to overflow
    always_comb begin
        if (lat[lhp_pkg::LAT_W-1]) begin
            add_idx = '0;
        end else if (lat > {{(lhp_pkg::LAT_W-lhp_pkg::RES_W){1'b0}}, lim_reg}) begin
            add_idx = last_idx;
        end else begin
            add_idx = IDX_W'(lat);
        end
    end

    // memory ports
    assign rd_addr = cmd.q_walk ? walk_addr_reg : add_idx;
    assign wr_en   = cmd.clear_step || cmd.add_write;
    assign wr_addr = cmd.clear_step ? clr_addr_reg : add_addr_reg;
    assign wr_data = cmd.clear_step ? '0 :
                     (&rd_data_reg) ? rd_data_reg : rd_data_reg + 32'd1;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    // limit, total and clear sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg      <= lhp_pkg::RES_W'(CAP);
            total_reg    <= '0;
            clr_addr_reg <= '0;
        end else if (cfg_we) begin
            lim_reg      <= (cfg_wdata > lhp_pkg::RES_W'(CAP)) ? lhp_pkg::RES_W'(CAP)
                                                               : cfg_wdata;
            total_reg    <= '0;
            clr_addr_reg <= '0;
        end else begin
            if (cmd.clear_step) clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (cmd.add_write && !(&total_reg)) total_reg <= total_reg + 32'd1;
        end
    end

    assign sts.clear_last = (clr_addr_reg == IDX_W'(BIN_COUNT - 1));
    assign sts.in_query   = s_tuser;
    assign sts.q_early    = (total_reg == '0) || (pct == '0) || (pct >= lhp_pkg::PCT_FULL);

    // bin count times 10000 as shifts and adds
    assign bin_ext = {{(lhp_pkg::PROD_W-lhp_pkg::CNT_W){1'b0}}, rd_data_reg};
    assign scaled  = (bin_ext << 13) + (bin_ext << 10) + (bin_ext << 9) +
                     (bin_ext << 8) + (bin_ext << 4);

    // walk compare: rank met in this bin, or the overflow bin reached
    // rem_reg holds p * total minus 10000 times the count of the bins passed
    assign hit      = (scaled >= rem_reg);
    assign at_last  = (data_idx_reg == last_idx);
    assign walk_end = cmd.q_walk && data_valid_reg && (hit || at_last);
    assign no_rank  = (total_reg == '0) || (pct == '0);
    assign sts.walk_done = walk_end;

    // query registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            add_addr_reg <= add_idx;
            pct_reg      <= pct;
            ans_reg      <= no_rank ? '0 : lim_reg;
        end
        if (cmd.q_mul) begin
            prod_reg <= {{(lhp_pkg::PROD_W-lhp_pkg::PCT_W){1'b0}}, pct_reg} *
                        {{(lhp_pkg::PROD_W-lhp_pkg::CNT_W){1'b0}}, total_reg};
        end
        if (cmd.q_load) begin
            rem_reg       <= prod_reg;
            walk_addr_reg <= '0;
        end
        if (cmd.q_walk) begin
            walk_addr_reg <= walk_addr_reg + IDX_W'(1);
            data_idx_reg  <= walk_addr_reg;
            if (data_valid_reg && !walk_end) rem_reg <= rem_reg - scaled;
            if (walk_end) ans_reg <= at_last ? lim_reg : lhp_pkg::RES_W'(data_idx_reg);
        end
    end

    // first walk cycle only issues the read of bin 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_valid_reg <= 1'b0;
        end else if (cmd.q_load) begin
            data_valid_reg <= 1'b0;
        end else if (cmd.q_walk) begin
            data_valid_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) out_data_reg <= ans_reg;
    end

    assign sts.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {{(lhp_pkg::M_TDATA_W-lhp_pkg::RES_W){1'b0}}, out_data_reg};

endmodule

[design/latency_histogram_percentile.sv]
`timescale 1ns / 1ps
// add item: bin read at accept, written back in the ADD state; the next item is taken after the write-back
// query: multiply, load, walk of bins 0 to j (j = bin meeting the rank, at most limit+1), output
//   step; early answers (no samples, p of 0 or at least 10000) skip the walk and go straight to output
// the output step waits while an earlier result is stalled; one bin read a cycle
// reset and every limit write clear all BIN_COUNT bins with no item accepted
// top level of the latency histogram; instantiates lhp_ctrl and lhp_dp, uses lhp_pkg

module latency_histogram_percentile #(
    parameter int BIN_COUNT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lhp_pkg::RES_W-1:0]       cfg_wdata,   // limit_ms
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lhp_pkg::S_TDATA_W-1:0]   s_tdata,     // sample latency, pct_hundredths
    input  logic                            s_tuser,     // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lhp_pkg::M_TDATA_W-1:0]   m_tdata      // percentile_ms
);

    lhp_pkg::cmd_t cmd;
    lhp_pkg::sts_t sts;

    // sequencing
    lhp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and arithmetic
    lhp_dp #(
        .BIN_COUNT (BIN_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[design/lhp_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the latency histogram top level, bound to it below
// depends on lhp_pkg for port widths

module lhp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_we,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lhp_pkg::M_TDATA_W-1:0] m_tdata
);

    // a limit write starts the clear pass
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input ready right after a limit write");

    // every accepted item clears input ready for the cycle after it
    a_item_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready in the cycle after an accepted item");

    // a result never reads as the reserved limit code and has no stray bits
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:0] != 10'h3FF) && (m_tdata[15:10] == 6'd0))
        else $error("result out of range");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind latency_histogram_percentile lhp_checker u_lhp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
